[rtl/assert_macros.svh]
// Assertion helpers for the page table mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is low.
`define PTM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ptm_pkg.sv]
`default_nettype none

package ptm_pkg;

	// Pool geometry
	localparam int TABLE_PAGES       = 64;
	localparam int PAGE_W            = $clog2(TABLE_PAGES);
	localparam int CNT_W             = $clog2(TABLE_PAGES + 1);
	localparam int IDX_W             = 9;
	localparam int ENTRIES_PER_TABLE = 1 << IDX_W;
	localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;
	localparam int ADDR_W            = PAGE_W + IDX_W;

	// Entry layout
	localparam int ENTRY_W = 52;
	localparam int PPN_W   = 40;
	localparam int OFS_W   = 12;
	localparam int LVL_W   = 2;

	localparam logic [PPN_W-1:0] BASE_RESET  = 40'd20480;
	localparam logic [OFS_W-1:0] PRESENT_RW  = 12'h003;
	localparam int               PRESENT_BIT = 0;

	typedef struct packed {
		logic [51:0] phys_addr;
		logic [47:0] virt_addr;
		logic [11:0] entry_flags;
	} req_t;

	typedef struct packed {
		logic [35:0] invalidate_page;
		logic [52:0] leaf_entry;
		logic [1:0]  tables_added;
		logic        pool_exhausted;
	} rsp_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [ENTRY_W-1:0] wdata;
		logic [ADDR_W-1:0]  raddr;
	} mem_port_t;

	typedef struct packed {
		logic              ok;
		logic [PAGE_W-1:0] page;
	} loc_t;

	typedef struct packed {
		logic idle;
		logic done;
	} walk_stat_t;

	// Store address of one entry of one pool page
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [PAGE_W-1:0] page,
			input logic [IDX_W-1:0] idx);
		return {page, idx};
	endfunction

	// Table index of a level, root level first
	function automatic logic [IDX_W-1:0] table_index(input logic [47:0] va,
			input logic [LVL_W-1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd0:    idx = va[47:39];
			2'd1:    idx = va[38:30];
			2'd2:    idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	// Physical address of pool page k, page number wrapping at 40 bits
	function automatic logic [ENTRY_W-1:0] page_address(input logic [PPN_W-1:0] base,
			input logic [PAGE_W-1:0] k);
		logic [PPN_W-1:0] ppn;
		ppn = base + PPN_W'(k);
		return {ppn, {OFS_W{1'b0}}};
	endfunction

	// Map an entry's address back to a pool page; ok is low outside the pool
	function automatic loc_t locate(input logic [ENTRY_W-1:0] entry,
			input logic [PPN_W-1:0] base);
		logic [PPN_W-1:0] off;
		loc_t loc;
		off      = entry[ENTRY_W-1:OFS_W] - base;
		loc.ok   = (off < PPN_W'(TABLE_PAGES));
		loc.page = off[PAGE_W-1:0];
		return loc;
	endfunction

endpackage

`default_nettype wire

[rtl/page_table_mapper.sv]
// Channel | Direction | Handshake                 | Word
// req     | in        | req_valid / req_stall     | req_t: phys_addr, virt_addr, entry_flags
// rsp     | out       | rsp_valid / rsp_stall     | rsp_t: invalidate_page, leaf_entry, ...
// cfg     | in        | cfg_valid / cfg_ready     | pool_base_page, 40 bits
//
// A request is walked in order: one table store read per level for a check walk,
// then, when applied, one read-modify-write per level and the leaf write, all on
// one store port pair; a rejected request skips the write-back walk.
// After reset a clearing pass zeroes all 32768 store entries (TABLE_PAGES * 512), one
// entry per cycle; req_stall stays high throughout, cfg writes are taken.
// A finished word waits in the output register while the next request is walked.
`default_nettype none
`include "assert_macros.svh"

module page_table_mapper
	import ptm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [39:0] cfg_data
);

	logic [PPN_W-1:0]   base_q;
	logic               clr_busy_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	mem_port_t          walk_port;
	mem_port_t          ram_port;
	logic [ENTRY_W-1:0] ram_rdata;
	walk_stat_t         walk_stat;
	rsp_t               walk_res;
	logic               start;
	logic               res_take;

	assign cfg_ready = 1'b1;

	// Hold the pool base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	// Sweep the store to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= ADDR_W'(clr_addr_q + 1'b1);
			if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign req_stall = clr_busy_q || !walk_stat.idle;
	assign start     = req_valid && !req_stall;

	// Steer the store write port to the clearing pass while it runs
	always_comb begin
		ram_port = walk_port;
		if (clr_busy_q) begin
			ram_port.we    = 1'b1;
			ram_port.waddr = clr_addr_q;
			ram_port.wdata = '0;
		end
	end

	ptm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_port.we),
		.waddr(ram_port.waddr),
		.wdata(ram_port.wdata),
		.raddr(ram_port.raddr),
		.rdata(ram_rdata)
	);

	ptm_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.base    (base_q),
		.mem     (walk_port),
		.rdata   (ram_rdata),
		.stat    (walk_stat),
		.res     (walk_res),
		.res_take(res_take)
	);

	// Load the output register when it is empty or being drained
	assign res_take = walk_stat.done && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= walk_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PTM_ASSERT(a_walk_idle_in_clear, clk, arst_n, clr_busy_q |-> walk_stat.idle, "walk during clearing pass")
	`PTM_ASSERT(a_reject_clean, clk, arst_n, (rsp_valid_q && rsp_q.pool_exhausted) |-> (rsp_q.leaf_entry == '0 && rsp_q.tables_added == '0), "rejected word carries data")
	`PTM_ASSERT(a_leaf_present, clk, arst_n, (rsp_valid_q && !rsp_q.pool_exhausted) |-> (rsp_q.leaf_entry[1:0] == 2'b11), "leaf not present and writable")

endmodule

`default_nettype wire

[rtl/ptm_ram.sv]
`default_nettype none

module ptm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; a colliding read sees old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/ptm_walker.sv]
`default_nettype none

module ptm_walker
	import ptm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  req_t               req,
	input  logic [PPN_W-1:0]   base,
	output mem_port_t          mem,
	input  logic [ENTRY_W-1:0] rdata,
	output walk_stat_t         stat,
	output rsp_t               res,
	input  logic               res_take
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DRY_RD = 3'd1;
	localparam logic [2:0] ST_DRY    = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_APPLY  = 3'd4;
	localparam logic [2:0] ST_LEAF   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]         state_q, state_d;
	req_t               req_q;
	logic [LVL_W-1:0]   lvl_q, lvl_d;
	logic [LVL_W-1:0]   need_q, need_d;
	logic               bad_q, bad_d;
	logic [PAGE_W-1:0]  page_q, page_d;
	logic [1:0]         added_q, added_d;
	logic [CNT_W-1:0]   next_free_q, next_free_d;
	rsp_t               res_q, res_d;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic               fwd_valid_q;
	logic [ADDR_W-1:0]  fwd_addr_q;
	logic [ENTRY_W-1:0] fwd_data_q;

	logic [ENTRY_W-1:0] entry;
	logic               present;
	loc_t               loc;
	logic               alloc;
	logic [PAGE_W-1:0]  new_page;
	logic [LVL_W-1:0]   lvl_next;
	logic [CNT_W:0]     free_sum;
	logic [ENTRY_W-1:0] flags_ext;

	// Take the write of the previous cycle when the store still returns old data
	assign entry     = (fwd_valid_q && (fwd_addr_q == rd_addr_q)) ? fwd_data_q : rdata;
	assign present   = entry[PRESENT_BIT];
	assign loc       = locate(entry, base);
	assign lvl_next  = LVL_W'(lvl_q + 1'b1);
	assign alloc     = !present && (next_free_q < CNT_W'(TABLE_PAGES));
	assign new_page  = alloc ? next_free_q[PAGE_W-1:0] : (loc.ok ? loc.page : '0);
	assign free_sum  = {1'b0, next_free_q} + (CNT_W+1)'(need_q);
	assign flags_ext = {{(ENTRY_W-OFS_W){1'b0}}, req_q.entry_flags};

	// Sequence the dry walk, the check, the write-back walk and the leaf write
	always_comb begin
		state_d     = state_q;
		lvl_d       = lvl_q;
		need_d      = need_q;
		bad_d       = bad_q;
		page_d      = page_q;
		added_d     = added_q;
		next_free_d = next_free_q;
		res_d       = res_q;
		mem.we      = 1'b0;
		mem.waddr   = slot_addr(page_q, table_index(req_q.virt_addr, lvl_q));
		mem.wdata   = entry | flags_ext;
		mem.raddr   = slot_addr('0, table_index(req_q.virt_addr, '0));
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DRY_RD;
				end
			end
			ST_DRY_RD: begin
				lvl_d   = '0;
				need_d  = '0;
				bad_d   = 1'b0;
				state_d = ST_DRY;
			end
			ST_DRY: begin
				mem.raddr = slot_addr(loc.page, table_index(req_q.virt_addr, lvl_next));
				if (!present) begin
					need_d  = LVL_W'(2'd3 - lvl_q);
					state_d = ST_CHECK;
				end else if (!loc.ok) begin
					bad_d   = 1'b1;
					state_d = ST_CHECK;
				end else if (lvl_q == 2'd2) begin
					state_d = ST_CHECK;
				end else begin
					lvl_d = lvl_next;
				end
			end
			ST_CHECK: begin
				lvl_d   = '0;
				added_d = '0;
				if (bad_q || (free_sum > (CNT_W+1)'(TABLE_PAGES))) begin
					res_d.invalidate_page = req_q.virt_addr[47:12];
					res_d.leaf_entry      = '0;
					res_d.tables_added    = '0;
					res_d.pool_exhausted  = 1'b1;
					state_d               = ST_DONE;
				end else begin
					page_d  = '0;
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				mem.we    = 1'b1;
				mem.raddr = slot_addr(new_page, table_index(req_q.virt_addr, lvl_next));
				if (alloc) begin
					mem.wdata   = page_address(base, next_free_q[PAGE_W-1:0])
						| flags_ext | {{(ENTRY_W-OFS_W){1'b0}}, PRESENT_RW};
					next_free_d = CNT_W'(next_free_q + 1'b1);
					added_d     = 2'(added_q + 1'b1);
				end
				page_d = new_page;
				if (lvl_q == 2'd2) begin
					state_d = ST_LEAF;
				end else begin
					lvl_d = lvl_next;
				end
			end
			ST_LEAF: begin
				mem.we    = 1'b1;
				mem.waddr = slot_addr(page_q, table_index(req_q.virt_addr, 2'd3));
				mem.wdata = {req_q.phys_addr[51:12], req_q.entry_flags | PRESENT_RW};
				res_d.invalidate_page = req_q.virt_addr[47:12];
				res_d.leaf_entry      = {1'b0, req_q.phys_addr[51:12],
					req_q.entry_flags | PRESENT_RW};
				res_d.tables_added    = added_q;
				res_d.pool_exhausted  = 1'b0;
				state_d               = ST_DONE;
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_free_q <= CNT_W'(1);
			fwd_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			next_free_q <= next_free_d;
			fwd_valid_q <= mem.we;
		end
	end

	// Hold request, walk position and forwarding data
	always_ff @(posedge clk) begin
		if (start && (state_q == ST_IDLE)) begin
			req_q <= req;
		end
		lvl_q      <= lvl_d;
		need_q     <= need_d;
		bad_q      <= bad_d;
		page_q     <= page_d;
		added_q    <= added_d;
		res_q      <= res_d;
		rd_addr_q  <= mem.raddr;
		fwd_addr_q <= mem.waddr;
		fwd_data_q <= mem.wdata;
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign res       = res_q;

endmodule

`default_nettype wire
